// ===== hw/rtl/bsmco_pkg.sv =====
// bsmco_pkg: command and status codes of the seeded maximum cardinality ordering block
// no dependencies
package bsmco_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_RUN    = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_BAD    = 2'd2
  } status_e;

endpackage

// ===== hw/rtl/bfs_seeded_max_cardinality_order.sv =====
// bfs_seeded_max_cardinality_order: graph load, breadth-first seeded maximum
// cardinality search ordering and order read-back, one sequencer over block memories
// depends on bsmco_pkg
//
//  channel | signals                                         | direction
//  in      | in_valid_i, in_stall_o, func_i, vertex_i,       | item in
//          | neighbour_i, vertex_count_i                     |
//  out     | out_valid_o, out_stall_i, vertex_out_o, status_o | result out
//
// read goes through the registered order memory read.
// clear sweeps all MAX_VERTICES entries of the degree memory.
// run: an init sweep of the vertex count, a probe of each root candidate, a walk over
//   each component vertex and adjacency entry, a start scan over the component, and
//   per pick a scan over the component vertices and score updates for its entries.
// the result of clear, run and append is loaded at acceptance; the input stalls
//   while the sequencer reads, sweeps or runs, or while a held result is stalled.
// reset clears control state only; memories hold no reset value.
module bfs_seeded_max_cardinality_order #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_ENTRIES  = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] vertex_i,
  input  logic [7:0] neighbour_i,
  input  logic [8:0] vertex_count_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] vertex_out_o,
  output logic [1:0] status_o
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = VW + 1;
  localparam int XW = (CW > 8) ? CW : 8;
  localparam logic [DW-1:0] UNV = {DW{1'b1}};

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_READ = 5'd2;
  localparam logic [4:0] S_INIT = 5'd3;
  localparam logic [4:0] S_ROOT = 5'd4;
  localparam logic [4:0] S_ROOTD = 5'd5;
  localparam logic [4:0] S_BPOP = 5'd6;
  localparam logic [4:0] S_BQ   = 5'd7;
  localparam logic [4:0] S_BV   = 5'd8;
  localparam logic [4:0] S_BK   = 5'd9;
  localparam logic [4:0] S_BA   = 5'd10;
  localparam logic [4:0] S_BU   = 5'd11;
  localparam logic [4:0] S_SQ   = 5'd12;
  localparam logic [4:0] S_SQD  = 5'd13;
  localparam logic [4:0] S_SVD  = 5'd14;
  localparam logic [4:0] S_SEL  = 5'd15;
  localparam logic [4:0] S_NK   = 5'd16;
  localparam logic [4:0] S_NA   = 5'd17;
  localparam logic [4:0] S_NU   = 5'd18;
  localparam logic [4:0] S_PQ   = 5'd19;
  localparam logic [4:0] S_PQD  = 5'd20;
  localparam logic [4:0] S_PVD  = 5'd21;

  // vertex memory (one read and one write address, per-field write enables)
  logic [EW-1:0] ls_mem    [MAX_VERTICES];
  logic [EW-1:0] deg_mem   [MAX_VERTICES];
  logic [DW-1:0] dist_mem  [MAX_VERTICES];
  logic [EW-1:0] score_mem [MAX_VERTICES];
  logic          chosen_mem[MAX_VERTICES];
  // position memory: walk queue and order
  logic [VW-1:0] queue_mem [MAX_VERTICES];
  logic [VW-1:0] order_mem [MAX_VERTICES];
  // adjacency memory
  logic [VW-1:0] adj_mem   [MAX_ENTRIES];

  logic [4:0]    state_q;
  logic [CW-1:0] gsize_q;
  logic [EW-1:0] ecount_q;
  logic          ready_q, have_q, found_q;
  logic [VW-1:0] last_q;
  logic [EW-1:0] own_ls_q, own_deg_q;
  logic [CW-1:0] i_q, root_q, head_q, tail_q, placed_q, picked_q;
  logic [EW-1:0] k_q, cur_ls_q, cur_deg_q;
  logic [DW-1:0] cur_dist_q, bdist_q;
  logic [VW-1:0] u_q, v_q, best_q;
  logic [EW-1:0] bdeg_q, bls_q, bscore_q;
  logic          out_valid_q;
  logic [7:0]    vout_q;
  bsmco_pkg::status_e status_q;

  logic [EW-1:0] ls_rd_q, deg_rd_q, score_rd_q;
  logic [DW-1:0] dist_rd_q;
  logic          chosen_rd_q;
  logic [VW-1:0] q_rd_q, o_rd_q, adj_rd_q;

  logic [VW-1:0] vtx_ra, vtx_wa, pos_ra, pos_wa;
  logic [AW-1:0] adj_ra, adj_wa;
  logic          we_ls, we_deg, we_dist, we_score, we_chosen, we_q, we_o, we_adj;
  logic [EW-1:0] wd_ls, wd_deg, wd_score;
  logic [DW-1:0] wd_dist;
  logic          wd_chosen;
  logic [VW-1:0] pos_wd, adj_wd;

  logic          in_acc, out_acc, new_owner, append_ok, better_start, better_pick;
  bsmco_pkg::func_e func;

  assign func       = bsmco_pkg::func_e'(func_i);
  assign out_acc    = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign new_owner  = !have_q || (VW'(vertex_i) != last_q);
  assign append_ok  = (XW'(vertex_i) < XW'(gsize_q)) && (XW'(neighbour_i) < XW'(gsize_q)) &&
                      (32'(ecount_q) < MAX_ENTRIES) &&
                      !(have_q && (XW'(vertex_i) < XW'(last_q)));
  assign better_start = (i_q == '0) || (dist_rd_q > bdist_q) ||
                        ((dist_rd_q == bdist_q) && (deg_rd_q < bdeg_q));
  assign better_pick  = !chosen_rd_q &&
                        (!found_q || (score_rd_q > bscore_q) ||
                         ((score_rd_q == bscore_q) &&
                          ((deg_rd_q < bdeg_q) || ((deg_rd_q == bdeg_q) && (v_q < best_q)))));

  always_comb begin
    vtx_ra = '0; pos_ra = '0; adj_ra = '0;
    vtx_wa = '0; pos_wa = '0; adj_wa = '0;
    we_ls = 1'b0; we_deg = 1'b0; we_dist = 1'b0; we_score = 1'b0; we_chosen = 1'b0;
    we_q = 1'b0; we_o = 1'b0; we_adj = 1'b0;
    wd_ls = '0; wd_deg = '0; wd_score = '0; wd_dist = '0; wd_chosen = 1'b0;
    pos_wd = '0; adj_wd = '0;
    unique case (state_q)
      S_IDLE: begin
        pos_ra = VW'(vertex_i);
        if (in_acc && (func == bsmco_pkg::FUNC_APPEND) && append_ok) begin
          we_adj = 1'b1;
          adj_wa = AW'(ecount_q);
          adj_wd = VW'(neighbour_i);
          vtx_wa = VW'(vertex_i);
          we_ls  = 1'b1;
          we_deg = 1'b1;
          wd_ls  = new_owner ? ecount_q : own_ls_q;
          wd_deg = new_owner ? EW'(1) : own_deg_q + EW'(1);
        end
      end
      S_CLR: begin
        vtx_wa = i_q[VW-1:0];
        we_deg = 1'b1;
      end
      S_INIT: begin
        vtx_wa    = i_q[VW-1:0];
        we_dist   = 1'b1;
        we_score  = 1'b1;
        we_chosen = 1'b1;
        wd_dist   = UNV;
      end
      S_ROOT: vtx_ra = root_q[VW-1:0];
      S_ROOTD: begin
        if (dist_rd_q == UNV) begin
          vtx_wa  = root_q[VW-1:0];
          we_dist = 1'b1;
          we_q    = 1'b1;
          pos_wd  = root_q[VW-1:0];
        end
      end
      S_BPOP: pos_ra = head_q[VW-1:0];
      S_BQ:   vtx_ra = q_rd_q;
      S_BK:   adj_ra = AW'(cur_ls_q + k_q);
      S_BA:   vtx_ra = adj_rd_q;
      S_BU: begin
        if (dist_rd_q == UNV) begin
          vtx_wa  = u_q;
          we_dist = 1'b1;
          wd_dist = cur_dist_q + DW'(1);
          pos_wa  = tail_q[VW-1:0];
          we_q    = 1'b1;
          pos_wd  = u_q;
        end
      end
      S_SQ:  pos_ra = i_q[VW-1:0];
      S_SQD: vtx_ra = q_rd_q;
      S_SEL: begin
        vtx_wa    = best_q;
        we_chosen = 1'b1;
        wd_chosen = 1'b1;
        pos_wa    = placed_q[VW-1:0];
        we_o      = 1'b1;
        pos_wd    = best_q;
      end
      S_NK: adj_ra = AW'(cur_ls_q + k_q);
      S_NA: vtx_ra = adj_rd_q;
      S_NU: begin
        if (!chosen_rd_q) begin
          vtx_wa   = u_q;
          we_score = 1'b1;
          wd_score = score_rd_q + EW'(1);
        end
      end
      S_PQ:  pos_ra = i_q[VW-1:0];
      S_PQD: vtx_ra = q_rd_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_ls)     ls_mem[vtx_wa]     <= wd_ls;
    if (we_deg)    deg_mem[vtx_wa]    <= wd_deg;
    if (we_dist)   dist_mem[vtx_wa]   <= wd_dist;
    if (we_score)  score_mem[vtx_wa]  <= wd_score;
    if (we_chosen) chosen_mem[vtx_wa] <= wd_chosen;
    if (we_q)      queue_mem[pos_wa]  <= pos_wd;
    if (we_o)      order_mem[pos_wa]  <= pos_wd;
    if (we_adj)    adj_mem[adj_wa]    <= adj_wd;
    ls_rd_q     <= ls_mem[vtx_ra];
    deg_rd_q    <= deg_mem[vtx_ra];
    dist_rd_q   <= dist_mem[vtx_ra];
    score_rd_q  <= score_mem[vtx_ra];
    chosen_rd_q <= chosen_mem[vtx_ra];
    q_rd_q      <= queue_mem[pos_ra];
    o_rd_q      <= order_mem[pos_ra];
    adj_rd_q    <= adj_mem[adj_ra];
  end

  // payload and loop registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          vout_q   <= '0;
          status_q <= bsmco_pkg::STATUS_OK;
          i_q      <= '0;
          root_q   <= '0;
          placed_q <= '0;
          if ((func == bsmco_pkg::FUNC_APPEND) && !append_ok) begin
            status_q <= bsmco_pkg::STATUS_REJECT;
          end
          if ((func == bsmco_pkg::FUNC_READ) &&
              (!ready_q || (XW'(vertex_i) >= XW'(gsize_q)))) begin
            status_q <= bsmco_pkg::STATUS_BAD;
          end
        end
      end
      S_READ: vout_q <= 8'(o_rd_q);
      S_CLR, S_INIT: i_q <= i_q + CW'(1);
      S_ROOTD: begin
        if (dist_rd_q != UNV) begin
          root_q <= root_q + CW'(1);
        end else begin
          head_q   <= '0;
          tail_q   <= CW'(1);
          picked_q <= '0;
        end
      end
      S_BV: begin
        cur_dist_q <= dist_rd_q;
        cur_ls_q   <= ls_rd_q;
        cur_deg_q  <= deg_rd_q;
        k_q        <= '0;
      end
      S_BPOP: i_q <= '0;
      S_BK: if (k_q == cur_deg_q) head_q <= head_q + CW'(1);
      S_BA, S_NA: u_q <= adj_rd_q;
      S_BU: begin
        k_q <= k_q + EW'(1);
        if (dist_rd_q == UNV) tail_q <= tail_q + CW'(1);
      end
      S_SQD, S_PQD: v_q <= q_rd_q;
      S_SVD: begin
        i_q <= i_q + CW'(1);
        if (better_start) begin
          best_q  <= v_q;
          bdist_q <= dist_rd_q;
          bdeg_q  <= deg_rd_q;
          bls_q   <= ls_rd_q;
        end
      end
      S_SEL: begin
        placed_q  <= placed_q + CW'(1);
        picked_q  <= picked_q + CW'(1);
        cur_ls_q  <= bls_q;
        cur_deg_q <= bdeg_q;
        k_q       <= '0;
      end
      S_NK: begin
        i_q     <= '0;
        found_q <= 1'b0;
        if (k_q == cur_deg_q && picked_q == tail_q) root_q <= root_q + CW'(1);
      end
      S_NU: k_q <= k_q + EW'(1);
      S_PVD: begin
        i_q <= i_q + CW'(1);
        if (better_pick) begin
          best_q   <= v_q;
          bscore_q <= score_rd_q;
          bdeg_q   <= deg_rd_q;
          bls_q    <= ls_rd_q;
          found_q  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gsize_q     <= '0;
      ecount_q    <= '0;
      ready_q     <= 1'b0;
      have_q      <= 1'b0;
      last_q      <= '0;
      own_ls_q    <= '0;
      own_deg_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_acc) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (func)
              bsmco_pkg::FUNC_CLEAR: begin
                out_valid_q <= 1'b1;
                gsize_q     <= (32'(vertex_count_i) > MAX_VERTICES) ?
                               CW'(MAX_VERTICES) : CW'(vertex_count_i);
                ecount_q    <= '0;
                ready_q     <= 1'b0;
                have_q      <= 1'b0;
                last_q      <= '0;
                state_q     <= S_CLR;
              end
              bsmco_pkg::FUNC_APPEND: begin
                out_valid_q <= 1'b1;
                if (append_ok) begin
                  ecount_q  <= ecount_q + EW'(1);
                  own_ls_q  <= new_owner ? ecount_q : own_ls_q;
                  own_deg_q <= new_owner ? EW'(1) : own_deg_q + EW'(1);
                  last_q    <= VW'(vertex_i);
                  have_q    <= 1'b1;
                  ready_q   <= 1'b0;
                end
              end
              bsmco_pkg::FUNC_RUN: begin
                out_valid_q <= 1'b1;
                state_q     <= (gsize_q == '0) ? S_ROOT : S_INIT;
              end
              bsmco_pkg::FUNC_READ: begin
                if (!ready_q || (XW'(vertex_i) >= XW'(gsize_q))) out_valid_q <= 1'b1;
                else state_q <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_CLR:  if (i_q == CW'(MAX_VERTICES - 1)) state_q <= S_IDLE;
        S_INIT: if (i_q == gsize_q - CW'(1)) state_q <= S_ROOT;
        S_ROOT: begin
          if (root_q == gsize_q) begin
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_ROOTD;
          end
        end
        S_ROOTD: state_q <= (dist_rd_q != UNV) ? S_ROOT : S_BPOP;
        S_BPOP:  state_q <= (head_q == tail_q) ? S_SQ : S_BQ;
        S_BQ:    state_q <= S_BV;
        S_BV:    state_q <= S_BK;
        S_BK:    state_q <= (k_q == cur_deg_q) ? S_BPOP : S_BA;
        S_BA:    state_q <= S_BU;
        S_BU:    state_q <= S_BK;
        S_SQ:    state_q <= (i_q == tail_q) ? S_SEL : S_SQD;
        S_SQD:   state_q <= S_SVD;
        S_SVD:   state_q <= S_SQ;
        S_SEL:   state_q <= S_NK;
        S_NK: begin
          if (k_q != cur_deg_q) state_q <= S_NA;
          else if (picked_q == tail_q) state_q <= S_ROOT;
          else state_q <= S_PQ;
        end
        S_NA:    state_q <= S_NU;
        S_NU:    state_q <= S_NK;
        S_PQ:    state_q <= (i_q == tail_q) ? S_SEL : S_PQD;
        S_PQD:   state_q <= S_PVD;
        S_PVD:   state_q <= S_PQ;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vertex_out_o = vout_q;
  assign status_o     = status_q;

`ifndef SYNTHESIS
  a_no_accept_over_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(out_valid_o && out_stall_i))
    else $error("input beat taken while a result beat is held");
  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (head_q <= tail_q || state_q == S_INIT || state_q == S_CLR ||
                             state_q == S_ROOT || state_q == S_ROOTD ||
                             state_q == S_READ))
    else $error("walk queue head passed its tail");
  a_entries_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecount_q) <= MAX_ENTRIES)
    else $error("adjacency entry count overflow");
  a_run_sets_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT && root_q == gsize_q) |=> (ready_q && state_q == S_IDLE))
    else $error("run finished without order ready");
`endif

endmodule

// ===== verif/testbench.sv =====
// testbench: checks graph load, seeded maximum cardinality ordering and order read-back
// of bfs_seeded_max_cardinality_order against a behavioral ordering predictor
// depends on bsmco_pkg and the block rtl
module testbench;

  localparam int NV = 256;
  localparam int NE = 2048;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [7:0]         vout;
    bsmco_pkg::status_e st;
  } answer_t;

  typedef struct {
    bsmco_pkg::func_e f;
    logic [7:0]       v;
    logic [7:0]       nb;
    logic [8:0]       cnt;
    bit               typed;
    answer_t          ans;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] func_i = bsmco_pkg::FUNC_CLEAR;
  logic [7:0] vertex_i = '0;
  logic [7:0] neighbour_i = '0;
  logic [8:0] vertex_count_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] vertex_out_o;
  logic [1:0] status_o;

  bfs_seeded_max_cardinality_order i_dut (.*);

  always #10 clk_i = ~clk_i;

  // ordering predictor state
  int adj_mem [NE];
  int list_at [NV];
  int deg [NV];
  int walk_depth [NV];
  bit seen [NV];
  int score [NV];
  bit chosen [NV];
  int walk [NV];
  int order_mem [NV];
  int vcount, entries, last_owner;
  bit have_entry, ready;

  answer_t pending_answers[$];
  int errors, cycles, beats_in, beats_out, runs_done, reads_ok, rejects;
  int send_idle_pct, recv_idle_pct;

  function automatic bit outranks(int a, int b);
    if (score[a] != score[b]) return score[a] > score[b];
    if (deg[a] != deg[b]) return deg[a] < deg[b];
    return a < b;
  endfunction

  function automatic void take_vertex(int v, ref int placed);
    int u;
    chosen[v] = 1'b1;
    order_mem[placed] = v;
    placed++;
    for (int k = 0; k < deg[v]; k++) begin
      u = adj_mem[list_at[v] + k];
      if (!chosen[u]) score[u]++;
    end
  endfunction

  function automatic void build_order();
    int placed, head, tail, start, best, u, v;
    bit found;
    placed = 0;
    for (int i = 0; i < NV; i++) begin
      seen[i] = 0; walk_depth[i] = 0; score[i] = 0; chosen[i] = 0;
    end
    for (int root = 0; root < vcount; root++) begin
      if (seen[root]) continue;
      head = 0; tail = 0;
      seen[root] = 1; walk_depth[root] = 0;
      walk[tail++] = root;
      while (head < tail) begin
        v = walk[head++];
        for (int k = 0; k < deg[v]; k++) begin
          u = adj_mem[list_at[v] + k];
          if (!seen[u]) begin
            seen[u] = 1; walk_depth[u] = walk_depth[v] + 1; walk[tail++] = u;
          end
        end
      end
      start = walk[0];
      for (int i = 0; i < tail; i++) begin
        v = walk[i];
        if (walk_depth[v] > walk_depth[start] ||
            (walk_depth[v] == walk_depth[start] && deg[v] < deg[start]))
          start = v;
      end
      take_vertex(start, placed);
      for (int p = 1; p < tail; p++) begin
        found = 0; best = 0;
        for (int i = 0; i < tail; i++) begin
          v = walk[i];
          if (chosen[v]) continue;
          if (!found || outranks(v, best)) begin
            best = v; found = 1;
          end
        end
        take_vertex(best, placed);
      end
    end
    ready = 1'b1;
  endfunction

  function automatic answer_t predict(bsmco_pkg::func_e f, int v, int nb, int cnt);
    answer_t a;
    a.vout = '0;
    a.st = bsmco_pkg::STATUS_OK;
    case (f)
      bsmco_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < NV; i++) deg[i] = 0;
        vcount = (cnt > NV) ? NV : cnt;
        entries = 0; ready = 0; last_owner = 0; have_entry = 0;
      end
      bsmco_pkg::FUNC_APPEND: begin
        if (v >= vcount || nb >= vcount || entries >= NE || (have_entry && v < last_owner))
          a.st = bsmco_pkg::STATUS_REJECT;
        else begin
          if (!have_entry || v != last_owner) list_at[v] = entries;
          adj_mem[entries] = nb;
          entries++;
          deg[v]++;
          last_owner = v; have_entry = 1; ready = 0;
        end
      end
      bsmco_pkg::FUNC_RUN: build_order();
      default: begin
        if (!ready || v >= vcount) a.st = bsmco_pkg::STATUS_BAD;
        else a.vout = order_mem[v][7:0];
      end
    endcase
    return a;
  endfunction

  task automatic report(string what, answer_t want);
    errors++;
    $display("mismatch at cycle %0d: %s, got vertex %0d status %0d, want vertex %0d status %0d",
             cycles, what, vertex_out_o, status_o, want.vout, want.st);
  endtask

  // one beat in, expectation queued at acceptance
  task automatic send(bsmco_pkg::func_e f, int v, int nb, int cnt, bit typed = 0,
                      answer_t ans = '0);
    answer_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i = f;
    vertex_i = v[7:0];
    neighbour_i = nb[7:0];
    vertex_count_i = cnt[8:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    a = predict(f, v, nb, cnt);
    if (typed && a != ans) begin
      errors++;
      $display("predictor disagrees with directed row at cycle %0d", cycles);
    end
    pending_answers.insert(pending_answers.size(), typed ? ans : a);
    beats_in++;
    if (f == bsmco_pkg::FUNC_RUN) runs_done++;
    if (f == bsmco_pkg::FUNC_READ && a.st == bsmco_pkg::STATUS_OK) reads_ok++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        want = pending_answers.pop_front();
        if (status_o != want.st) report("status", want);
        else if (vertex_out_o != want.vout) report("vertex", want);
        if (want.st == bsmco_pkg::STATUS_REJECT) rejects++;
      end
    end
  end

  function automatic answer_t ans(int v, bsmco_pkg::status_e s);
    answer_t a;
    a.vout = v[7:0];
    a.st = s;
    return a;
  endfunction

  // random graph on n vertices: symmetric edges, lists emitted in owner order, random noise appends mixed in
  task automatic random_graph(int n);
    int lists [NV][$];
    int m, a, b;
    m = $urandom_range(2 * n);
    for (int e = 0; e < m; e++) begin
      a = $urandom_range(n - 1);
      b = ($urandom_range(9) == 0) ? a : $urandom_range(n - 1);
      lists[a].insert(lists[a].size(), b);
      if (a != b) lists[b].insert(lists[b].size(), a);
    end
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < lists[i].size(); k++) begin
        if ($urandom_range(39) == 0)
          send(bsmco_pkg::FUNC_APPEND, $urandom_range(255), $urandom_range(255), 0);
        send(bsmco_pkg::FUNC_APPEND, i, lists[i][k], $urandom_range(511));
      end
    end
  endtask

  task automatic random_part(int budget);
    int n, stop_at, pick;
    stop_at = beats_in + budget;
    while (beats_in < stop_at) begin
      if ($urandom_range(7) == 0) drain();
      pick = $urandom_range(19);
      n = (pick == 0) ? $urandom_range(13, 40) :
          (pick == 1) ? $urandom_range(257, 511) : $urandom_range(1, 12);
      if (pick == 1) begin
        // saturating clear, then only noise and no run
        send(bsmco_pkg::FUNC_CLEAR, 0, 0, n);
        send(bsmco_pkg::FUNC_APPEND, $urandom_range(255), $urandom_range(255), 0);
        send(bsmco_pkg::FUNC_READ, $urandom_range(255), 0, 0);
        continue;
      end
      send(bsmco_pkg::FUNC_CLEAR, $urandom_range(255), $urandom_range(255), n);
      random_graph(n);
      if ($urandom_range(5) == 0) send(bsmco_pkg::FUNC_READ, $urandom_range(n), 0, 0);
      send(bsmco_pkg::FUNC_RUN, $urandom_range(255), $urandom_range(255),
           $urandom_range(511));
      for (int p = 0; p <= n; p++) send(bsmco_pkg::FUNC_READ, p, $urandom_range(255), 0);
      send(bsmco_pkg::FUNC_READ, $urandom_range(255), 0, 0);
      if ($urandom_range(3) == 0) begin
        send(bsmco_pkg::FUNC_APPEND, n - 1, $urandom_range(n - 1), 0);
        send(bsmco_pkg::FUNC_READ, 0, 0, 0);
        send(bsmco_pkg::FUNC_RUN, 0, 0, 0);
        send(bsmco_pkg::FUNC_READ, $urandom_range(n - 1), 0, 0);
      end
    end
  endtask

  row_t rows [$];

  initial begin
    rows = '{
      '{bsmco_pkg::FUNC_READ,   8'd0,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_BAD)},
      '{bsmco_pkg::FUNC_APPEND, 8'd0,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_REJECT)},
      '{bsmco_pkg::FUNC_RUN,    8'd0,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_OK)},
      '{bsmco_pkg::FUNC_READ,   8'd0,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_BAD)},
      '{bsmco_pkg::FUNC_CLEAR,  8'd0,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_OK)},
      '{bsmco_pkg::FUNC_RUN,    8'd0,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_OK)},
      '{bsmco_pkg::FUNC_READ,   8'd0,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_BAD)},
      '{bsmco_pkg::FUNC_CLEAR,  8'd255, 8'd255, 9'd511, 1, ans(0, bsmco_pkg::STATUS_OK)},
      '{bsmco_pkg::FUNC_APPEND, 8'd255, 8'd255, 9'd0,   1, ans(0, bsmco_pkg::STATUS_OK)},
      '{bsmco_pkg::FUNC_APPEND, 8'd3,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_REJECT)},
      '{bsmco_pkg::FUNC_CLEAR,  8'd0,   8'd0,   9'd5,   1, ans(0, bsmco_pkg::STATUS_OK)},
      '{bsmco_pkg::FUNC_APPEND, 8'd5,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_REJECT)},
      '{bsmco_pkg::FUNC_APPEND, 8'd0,   8'd7,   9'd0,   1, ans(0, bsmco_pkg::STATUS_REJECT)},
      '{bsmco_pkg::FUNC_APPEND, 8'd0,   8'd1,   9'd0,   0, '0},
      '{bsmco_pkg::FUNC_APPEND, 8'd1,   8'd0,   9'd0,   0, '0},
      '{bsmco_pkg::FUNC_APPEND, 8'd1,   8'd2,   9'd0,   0, '0},
      '{bsmco_pkg::FUNC_APPEND, 8'd2,   8'd2,   9'd0,   0, '0},
      '{bsmco_pkg::FUNC_APPEND, 8'd3,   8'd4,   9'd0,   0, '0},
      '{bsmco_pkg::FUNC_APPEND, 8'd3,   8'd4,   9'd0,   0, '0},
      '{bsmco_pkg::FUNC_APPEND, 8'd0,   8'd1,   9'd0,   1, ans(0, bsmco_pkg::STATUS_REJECT)},
      '{bsmco_pkg::FUNC_RUN,    8'd0,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_OK)},
      '{bsmco_pkg::FUNC_READ,   8'd0,   8'd0,   9'd0,   0, '0},
      '{bsmco_pkg::FUNC_READ,   8'd4,   8'd0,   9'd0,   0, '0},
      '{bsmco_pkg::FUNC_READ,   8'd5,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_BAD)},
      '{bsmco_pkg::FUNC_APPEND, 8'd4,   8'd3,   9'd0,   1, ans(0, bsmco_pkg::STATUS_OK)},
      '{bsmco_pkg::FUNC_READ,   8'd1,   8'd0,   9'd0,   1, ans(0, bsmco_pkg::STATUS_BAD)}
    };
    void'(predict(bsmco_pkg::FUNC_CLEAR, 0, 0, 0));
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 22;
    recv_idle_pct = 80;
    foreach (rows[i]) send(rows[i].f, rows[i].v, rows[i].nb, rows[i].cnt,
                           rows[i].typed, rows[i].ans);
    drain();
    random_part(300);

    send_idle_pct = 80;
    recv_idle_pct = 22;
    random_part(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_part(300);

    // every vertex present, then one pass over the largest graph
    drain();
    send(bsmco_pkg::FUNC_CLEAR, 0, 0, 256);
    for (int e = 0; e < 320; e++)
      send(bsmco_pkg::FUNC_APPEND, (e * 4) / 5, $urandom_range(255), 0);
    send(bsmco_pkg::FUNC_APPEND, 255, 0, 0);
    send(bsmco_pkg::FUNC_RUN, 0, 0, 0);
    for (int p = 0; p < 256; p += 17) send(bsmco_pkg::FUNC_READ, p, 0, 0);
    send(bsmco_pkg::FUNC_READ, 255, 0, 0);

    drain();
    repeat (300) @(negedge clk_i);
    $display("%0d beats in, %0d results, %0d orderings run, %0d good reads, %0d rejected appends",
             beats_in, beats_out, runs_done, reads_ok, rejects);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== bfs_seeded_max_cardinality_order.f =====
hw/rtl/bsmco_pkg.sv
hw/rtl/bfs_seeded_max_cardinality_order.sv
verif/testbench.sv
